[hdl/nlca_pkg.sv]
`timescale 1ns / 1ps
// Package for the tempered cellular-automaton generator.
// Holds the array sizes, command codes, tempering constants and shared types.
// It depends on nothing else.
package nlca_pkg;

	localparam int CELL_COUNT     = 1409;
	localparam int WORDS_PER_STEP = 44;
	localparam int WORD_W         = 32;
	localparam int CHUNK_W        = 64;
	localparam int CHUNK_IDX_W    = 5;

	localparam int POS_W     = $clog2(WORDS_PER_STEP + 1);
	localparam int READ_W    = (WORDS_PER_STEP * WORD_W > CELL_COUNT) ?
		WORDS_PER_STEP * WORD_W : CELL_COUNT;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_GEN  = 1'b1;

	localparam logic [WORD_W-1:0] TEMPER_MASK_B = 32'h9d2c5680;
	localparam logic [WORD_W-1:0] TEMPER_MASK_C = 32'hefc60000;
	localparam int TEMPER_SHIFT_U = 11;
	localparam int TEMPER_SHIFT_S = 7;
	localparam int TEMPER_SHIFT_T = 15;
	localparam int TEMPER_SHIFT_L = 18;

	typedef struct packed {
		logic load;
		logic gen;
	} nlca_cmd_t;

endpackage

[hdl/nlca_temper.sv]
`timescale 1ns / 1ps
// Tempering stage: four shift and XOR steps, two of them masked, applied to one raw word.
// Uses the constants of nlca_pkg.
module nlca_temper (
	input  logic [nlca_pkg::WORD_W-1:0] raw_word,
	output logic [nlca_pkg::WORD_W-1:0] tempered_word
);

	logic [nlca_pkg::WORD_W-1:0] y1;
	logic [nlca_pkg::WORD_W-1:0] y2;
	logic [nlca_pkg::WORD_W-1:0] y3;

	assign y1 = raw_word ^ (raw_word >> nlca_pkg::TEMPER_SHIFT_U);
	assign y2 = y1 ^ ((y1 << nlca_pkg::TEMPER_SHIFT_S) & nlca_pkg::TEMPER_MASK_B);
	assign y3 = y2 ^ ((y2 << nlca_pkg::TEMPER_SHIFT_T) & nlca_pkg::TEMPER_MASK_C);
	assign tempered_word = y3 ^ (y3 >> nlca_pkg::TEMPER_SHIFT_L);

endmodule

[hdl/nlca_automaton.sv]
`timescale 1ns / 1ps
// Cell array, next-state rules, seed loading and word selection of the generator.
// Uses the sizes and types of nlca_pkg.
module nlca_automaton (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nlca_pkg::nlca_cmd_t              cmd,
	input  logic [nlca_pkg::CHUNK_IDX_W-1:0] chunk_index,
	input  logic [nlca_pkg::CHUNK_W-1:0]     seed_bits,
	output logic [nlca_pkg::WORD_W-1:0]      raw_word
);

	localparam int N = nlca_pkg::CELL_COUNT;
	localparam int W = nlca_pkg::WORDS_PER_STEP;
	localparam int IDX_W = (W > 1) ? $clog2(W) : 1;

	logic [N-1:0]                  cells_q;
	logic [N-1:0]                  next_cells;
	logic [N-1:0]                  load_cells;
	logic [nlca_pkg::POS_W-1:0]    word_position_q;
	logic                          advance;
	logic [IDX_W-1:0]              read_idx;
	logic [nlca_pkg::READ_W-1:0]   read_src;
	logic [nlca_pkg::WORD_W-1:0]   picked;

	for (genvar i = 0; i < N; i++) begin : g_rule
		if (i == 0) begin : g_first
			assign next_cells[i] = cells_q[1];
		end else if (i == N - 1) begin : g_last
			assign next_cells[i] = cells_q[i-1] ^ cells_q[i];
		end else if (i >= 5 && ((i - 5) % 6) == 0) begin : g_special
			localparam int K = ((i - 5) / 6) % 4;
			logic l, c, r;
			assign l = cells_q[i-1];
			assign c = cells_q[i];
			assign r = cells_q[i+1];
			if (K == 0) begin : g_r86
				assign next_cells[i] = (l | c) ^ r;
			end else if (K == 1) begin : g_r149
				assign next_cells[i] = (l & c) ^ ~r;
			end else if (K == 2) begin : g_r101
				assign next_cells[i] = l ^ (l & c) ^ ~r;
			end else begin : g_r154
				assign next_cells[i] = l ^ (l & c) ^ r;
			end
		end else begin : g_r150
			assign next_cells[i] = cells_q[i-1] ^ cells_q[i] ^ cells_q[i+1];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_load
		assign load_cells[i] = (int'(chunk_index) == (i / nlca_pkg::CHUNK_W)) ?
			seed_bits[i % nlca_pkg::CHUNK_W] : cells_q[i];
	end

	assign advance  = (word_position_q >= nlca_pkg::POS_W'(W));
	assign read_idx = advance ? '0 : word_position_q[IDX_W-1:0];

	always_comb begin
		read_src = '0;
		read_src[N-1:0] = advance ? next_cells : cells_q;
	end

	always_comb begin
		picked = '0;
		for (int w = 0; w < W; w++) begin
			if (read_idx == IDX_W'(w)) begin
				picked = read_src[w*nlca_pkg::WORD_W +: nlca_pkg::WORD_W];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < nlca_pkg::WORD_W; j++) begin
			raw_word[nlca_pkg::WORD_W-1-j] = picked[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q         <= '0;
			word_position_q <= nlca_pkg::POS_W'(W);
		end else if (cmd.load) begin
			cells_q         <= load_cells;
			word_position_q <= nlca_pkg::POS_W'(W);
		end else if (cmd.gen) begin
			if (advance) begin
				cells_q         <= next_cells;
				word_position_q <= nlca_pkg::POS_W'(1);
			end else begin
				word_position_q <= word_position_q + nlca_pkg::POS_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		word_position_q <= nlca_pkg::POS_W'(W))
		else $error("word position beyond the words of one state");
	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> word_position_q == nlca_pkg::POS_W'(W))
		else $error("load did not force an update before the next word");
	a_step_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.gen && advance) |=> word_position_q == nlca_pkg::POS_W'(1))
		else $error("update did not restart the word count");
`endif

endmodule

[hdl/nonlinear_ca_prng_tempered_unit.sv]
`timescale 1ns / 1ps
// Top level of the tempered cellular-automaton generator: handshakes and result register.
// Instantiates nlca_automaton and nlca_temper and uses nlca_pkg.
//
// A new input item can be accepted in every cycle in which in_stall is low.
// A load item (command 0) writes up to 64 seed bits into one chunk of the
// 1409-cell automaton (none for a chunk index past the last chunk) and gives
// no result; it also makes the next generate item update all cells first. A
// generate item (command 1) updates the whole automaton in that same cycle
// when all 44 words of the current state have been used, selects one 32-bit
// word, tempers it and places it in the result register, so the word appears
// on the output in the cycle after the item is accepted. The input side
// stalls only while a result waits and the output side stalls.
module nonlinear_ca_prng_tempered_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [nlca_pkg::CHUNK_IDX_W-1:0] chunk_index,
	input  logic [nlca_pkg::CHUNK_W-1:0]     seed_bits,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [nlca_pkg::WORD_W-1:0]      random_word
);

	logic                         in_accept;
	nlca_pkg::nlca_cmd_t          cmd;
	logic [nlca_pkg::WORD_W-1:0]  raw_word;
	logic [nlca_pkg::WORD_W-1:0]  tempered_word;
	logic                         out_valid_q;
	logic [nlca_pkg::WORD_W-1:0]  random_word_q;

	assign in_stall  = out_valid_q & out_stall;
	assign in_accept = in_valid & ~in_stall;
	assign cmd.load  = in_accept & (command == nlca_pkg::CMD_LOAD);
	assign cmd.gen   = in_accept & (command == nlca_pkg::CMD_GEN);

	nlca_automaton u_automaton (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.chunk_index (chunk_index),
		.seed_bits   (seed_bits),
		.raw_word    (raw_word)
	);

	nlca_temper u_temper (
		.raw_word      (raw_word),
		.tempered_word (tempered_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.gen) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gen) begin
			random_word_q <= tempered_word;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

`ifndef NO_ASSERTIONS
	a_gen_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gen |=> out_valid)
		else $error("generate item gave no result");
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !out_valid)
		else $error("load item gave a result");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled with no waiting result");
`endif

endmodule

[verif/tb_nonlinear_ca_prng_tempered_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for nonlinear_ca_prng_tempered_unit: seed loads and word generation
// are checked against an in-bench model of the automaton and the tempering stage.
// Depends on nlca_pkg and the RTL of the block only.
module tb_nonlinear_ca_prng_tempered_unit;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int LAST_CHUNK     = (nlca_pkg::CELL_COUNT - 1) / nlca_pkg::CHUNK_W;
	localparam int TOP_CHUNK      = (1 << nlca_pkg::CHUNK_IDX_W) - 1;

	logic                             clk;
	logic                             arst_n;
	logic                             in_valid;
	logic                             in_stall;
	logic                             command;
	logic [nlca_pkg::CHUNK_IDX_W-1:0] chunk_index;
	logic [nlca_pkg::CHUNK_W-1:0]     seed_bits;
	logic                             out_valid;
	logic                             out_stall;
	logic [nlca_pkg::WORD_W-1:0]      random_word;

	logic [nlca_pkg::CELL_COUNT-1:0] ca_cells;
	int                              words_used;
	logic [nlca_pkg::WORD_W-1:0]     expected_words[$];
	int                              mismatch_count;
	int                              idle_cycles;
	int                              send_idle_pct;
	int                              recv_stall_pct;

	nonlinear_ca_prng_tempered_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.chunk_index (chunk_index),
		.seed_bits   (seed_bits),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [nlca_pkg::CELL_COUNT-1:0] next_generation(
		input logic [nlca_pkg::CELL_COUNT-1:0] cur);
		logic [nlca_pkg::CELL_COUNT-1:0] nxt;
		logic                            l;
		logic                            c;
		logic                            r;
		int                              k;
		nxt[0] = cur[1];
		for (int i = 1; i < nlca_pkg::CELL_COUNT - 1; i++)
			nxt[i] = cur[i-1] ^ cur[i] ^ cur[i+1];
		k = 0;
		// Every sixth cell from cell 5 follows one of four nonlinear rules in turn.
		for (int i = 5; i < nlca_pkg::CELL_COUNT - 1; i += 6) begin
			l = cur[i-1];
			c = cur[i];
			r = cur[i+1];
			case (k % 4)
				0: begin
					nxt[i] = (l | c) ^ r;
				end
				1: begin
					nxt[i] = (l & c) ^ ~r;
				end
				2: begin
					nxt[i] = l ^ (l & c) ^ ~r;
				end
				default: begin
					nxt[i] = l ^ (l & c) ^ r;
				end
			endcase
			k++;
		end
		nxt[nlca_pkg::CELL_COUNT-1] = cur[nlca_pkg::CELL_COUNT-2] ^ cur[nlca_pkg::CELL_COUNT-1];
		return nxt;
	endfunction

	function automatic logic [nlca_pkg::WORD_W-1:0] temper_word(
		input logic [nlca_pkg::WORD_W-1:0] raw);
		logic [nlca_pkg::WORD_W-1:0] y;
		y = raw;
		y ^= y >> nlca_pkg::TEMPER_SHIFT_U;
		y ^= (y << nlca_pkg::TEMPER_SHIFT_S) & nlca_pkg::TEMPER_MASK_B;
		y ^= (y << nlca_pkg::TEMPER_SHIFT_T) & nlca_pkg::TEMPER_MASK_C;
		y ^= y >> nlca_pkg::TEMPER_SHIFT_L;
		return y;
	endfunction

	function automatic void apply_item(input logic cmd,
		input logic [nlca_pkg::CHUNK_IDX_W-1:0] idx, input logic [nlca_pkg::CHUNK_W-1:0] bits);
		logic [nlca_pkg::WORD_W-1:0] raw;
		int                          pos;
		if (cmd == nlca_pkg::CMD_LOAD) begin
			for (int i = 0; i < nlca_pkg::CHUNK_W; i++) begin
				pos = int'(idx) * nlca_pkg::CHUNK_W + i;
				if (pos < nlca_pkg::CELL_COUNT)
					ca_cells[pos] = bits[i];
			end
			words_used = nlca_pkg::WORDS_PER_STEP;
		end else begin
			if (words_used >= nlca_pkg::WORDS_PER_STEP) begin
				ca_cells = next_generation(ca_cells);
				words_used = 0;
			end
			raw = '0;
			for (int i = 0; i < nlca_pkg::WORD_W; i++) begin
				pos = words_used * nlca_pkg::WORD_W + i;
				raw = {raw[nlca_pkg::WORD_W-2:0],
					(pos < nlca_pkg::CELL_COUNT) ? ca_cells[pos] : 1'b0};
			end
			words_used++;
			expected_words.push_back(temper_word(raw));
		end
	endfunction

	function automatic void flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic logic [nlca_pkg::CHUNK_W-1:0] rand_seed();
		return {$urandom, $urandom};
	endfunction

	task automatic send_item(input logic cmd, input logic [nlca_pkg::CHUNK_IDX_W-1:0] idx,
		input logic [nlca_pkg::CHUNK_W-1:0] bits);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		chunk_index <= idx;
		seed_bits   <= bits;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_item(cmd, idx, bits);
	endtask

	task automatic send_load(input int idx, input logic [nlca_pkg::CHUNK_W-1:0] bits);
		send_item(nlca_pkg::CMD_LOAD, nlca_pkg::CHUNK_IDX_W'(idx), bits);
	endtask

	// Chunk and seed fields are don't-care on a generate item, so they carry noise.
	task automatic send_generate();
		send_item(nlca_pkg::CMD_GEN, nlca_pkg::CHUNK_IDX_W'($urandom_range(TOP_CHUNK)),
			rand_seed());
	endtask

	task automatic run_random_traffic(input int count);
		int sent;
		int choice;
		int run_len;
		int idx;
		sent = 0;
		while (sent < count) begin
			choice = $urandom_range(99);
			if (choice < 8) begin
				for (int c = 0; c <= LAST_CHUNK; c++)
					send_load(c, rand_seed());
				sent += LAST_CHUNK + 1;
			end else if (choice < 75) begin
				run_len = $urandom_range(3);
				for (int n = 0; n < run_len; n++) begin
					idx = ($urandom_range(9) == 0) ? $urandom_range(TOP_CHUNK, LAST_CHUNK + 1)
						: $urandom_range(LAST_CHUNK);
					send_load(idx, rand_seed());
				end
				sent += run_len;
				run_len = $urandom_range(100, 1);
				repeat (run_len)
					send_generate();
				sent += run_len;
			end else begin
				run_len = $urandom_range(10, 1);
				repeat (run_len)
					send_item(1'($urandom_range(1)),
						nlca_pkg::CHUNK_IDX_W'($urandom_range(TOP_CHUNK)), rand_seed());
				sent += run_len;
			end
		end
	endtask

	task automatic test_seed_edges();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		// Words from the all-zero state right after reset.
		send_generate();
		send_generate();
		send_load(0, {nlca_pkg::CHUNK_W{1'b1}});
		send_load(LAST_CHUNK, {nlca_pkg::CHUNK_W{1'b1}});
		send_load(TOP_CHUNK, {nlca_pkg::CHUNK_W{1'b1}});
		send_load(LAST_CHUNK + 1, {(nlca_pkg::CHUNK_W/2){2'b10}});
		send_generate();
		send_generate();
		send_load(10, '0);
		send_load(LAST_CHUNK - 1, {(nlca_pkg::CHUNK_W/2){2'b01}});
		send_generate();
		send_generate();
		send_generate();
		send_load(LAST_CHUNK, {{(nlca_pkg::CHUNK_W-1){1'b1}}, 1'b0});
		send_generate();
		// An out-of-range load still forces a fresh generation.
		send_load(TOP_CHUNK, '0);
		send_generate();
		send_load(0, 64'h8000_0000_0000_0001);
		send_generate();
		send_generate();
	endtask

	task automatic test_free_running_stream();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random_traffic(320);
	endtask

	task automatic test_sender_gaps();
		send_idle_pct  = 84;
		recv_stall_pct = 0;
		run_random_traffic(320);
	endtask

	task automatic test_receiver_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 84;
		run_random_traffic(320);
	endtask

	task automatic test_both_sides_idle();
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		run_random_traffic(320);
	endtask

	always @(posedge clk) begin
		logic [nlca_pkg::WORD_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				flag_mismatch($sformatf("unexpected word %08h with nothing expected",
					random_word));
			end else begin
				want = expected_words.pop_front();
				if (random_word !== want)
					flag_mismatch($sformatf("random_word mismatch: expected %08h, got %08h",
						want, random_word));
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("nonlinear_ca_prng_tempered_unit verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		command        <= nlca_pkg::CMD_LOAD;
		chunk_index    <= '0;
		seed_bits      <= '0;
		out_stall      <= 1'b0;
		ca_cells        = '0;
		words_used      = nlca_pkg::WORDS_PER_STEP;
		mismatch_count  = 0;
		idle_cycles     = 0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_seed_edges();
		test_free_running_stream();
		test_sender_gaps();
		test_receiver_backpressure();
		test_both_sides_idle();

		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (expected_words.size() != 0)
			flag_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));
		if (mismatch_count == 0) begin
			$display("nonlinear_ca_prng_tempered_unit verification clean");
		end else begin
			$display("nonlinear_ca_prng_tempered_unit verification failed");
		end
		$finish;
	end

endmodule
